// File: rtl/dtgf_pkg.sv
package dtgf_pkg;

   localparam int MulWidth = 16;
   localparam int MulCntWidth = 4;

   localparam int PhaseWidth = 16;
   localparam int FrameWidth = 15;
   localparam int SampleWidth = 15;
   localparam int FadeWidth = 10;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   // register index codes, taken from address bit 2
   localparam logic RegPhaseIncrement = 1'b0;
   localparam logic RegToneFrames = 1'b1;

   localparam logic [15:0] QuarterWave = 16'd16384;
   localparam logic [16:0] HalfWave = 17'd32768;
   localparam logic [16:0] FullWave = 17'h10000;
   localparam logic [15:0] FadeLen = 16'd512;
   localparam logic [FadeWidth-1:0] FadeUnity = 10'd512;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase_increment;
      logic [FrameWidth-1:0] tone_frames;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

// File: rtl/dtgf_sermul.sv
module dtgf_sermul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [dtgf_pkg::MulWidth-1:0]       mcand,
   input  logic [dtgf_pkg::MulWidth-1:0]       mplier,
   output dtgf_pkg::mul_status_type            status,
   output logic [2*dtgf_pkg::MulWidth-1:0]     product
);
   import dtgf_pkg::*;

   localparam logic [MulCntWidth-1:0] CntLast = MulCntWidth'(MulWidth - 1);

   logic [2*MulWidth-1:0] acc_ff, acc_in;
   logic [MulWidth-1:0] mcand_ff, mcand_in;
   logic [MulCntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [MulWidth:0] sum;

   // one multiplier bit per cycle, lsb first, product shifts right
   assign sum = {1'b0, acc_ff[2*MulWidth-1:MulWidth]}
              + (acc_ff[0] ? {1'b0, mcand_ff} : {(MulWidth+1){1'b0}});

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = {{MulWidth{1'b0}}, mplier};
         mcand_in = mcand;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[MulWidth-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/dtgf_csr.sv
module dtgf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dtgf_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [dtgf_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [dtgf_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output dtgf_pkg::cfg_type                    cfg
);
   import dtgf_pkg::*;

   logic [PhaseWidth-1:0] phase_increment_ff, phase_increment_in;
   logic [FrameWidth-1:0] tone_frames_ff, tone_frames_in;
   logic wr_en;
   logic reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[2];

   always_comb begin
      phase_increment_in = phase_increment_ff;
      tone_frames_in = tone_frames_ff;
      if (wr_en) begin
         case (reg_sel)
            RegPhaseIncrement: phase_increment_in = csr_pwdata[PhaseWidth-1:0];
            RegToneFrames: tone_frames_in = csr_pwdata[FrameWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         RegPhaseIncrement:
            csr_prdata = {{(CsrDataWidth-PhaseWidth){1'b0}}, phase_increment_ff};
         RegToneFrames:
            csr_prdata = {{(CsrDataWidth-FrameWidth){1'b0}}, tone_frames_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_increment_ff <= 16'd600;
         tone_frames_ff <= 15'd12000;
      end else begin
         phase_increment_ff <= phase_increment_in;
         tone_frames_ff <= tone_frames_in;
      end
   end

   assign cfg.phase_increment = phase_increment_ff;
   assign cfg.tone_frames = tone_frames_ff;

endmodule

// File: rtl/dds_tone_generator_with_fade_core.sv
// Phase-accumulator tone generator with a parabolic sine shape and a linear
// fade of 512 frames at both ends of the tone.
// Input channel (req_): one item per audio tick. req_restart = 1 starts the
// tone over from phase zero; a plain tick yields the next frame while the
// tone plays and nothing when it is idle or past its end.
// Result channel (rsp_): one signed sample for both stereo channels and a
// flag on the final frame of the tone.
// Configuration (csr_): phase increment at address 0, tone length at 4; they are
// to be written only while the block is idle, which the block itself does not enforce.
// Timing: a frame tick passes through StWave, StFade and StOut before rsp_valid
// rises, and the next tick can be taken while rsp_valid is high. The work uses
// one shared shift-add multiplier that retires one multiplier bit per cycle
// and runs twice per frame (wave, then fade).
// A tick with no result is finished in the cycle it is accepted. One item
// is in flight at a time; the next is taken while a result still waits.
// When the receiver stalls, the finished result holds on rsp_ and the block
// waits before writing a new one.
// Reset: tone idle, phase and frame count zero, increment 600, length 12000.
module dds_tone_generator_with_fade_core #(
   parameter int MAX_FRAMES = 16384
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_restart,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [dtgf_pkg::SampleWidth-1:0]     rsp_sample,
   output logic                                        rsp_last_frame,
   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [dtgf_pkg::CsrAddrWidth-1:0]           csr_paddr,
   input  logic [dtgf_pkg::CsrDataWidth-1:0]           csr_pwdata,
   output logic [dtgf_pkg::CsrDataWidth-1:0]           csr_prdata,
   output logic                                        csr_pready
);
   import dtgf_pkg::*;

   localparam logic [15:0] MaxLen = 16'(MAX_FRAMES);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StWave = 2'd1;
   localparam logic [1:0] StFade = 2'd2;
   localparam logic [1:0] StOut  = 2'd3;

   cfg_type cfg;
   mul_status_type mul_status;
   logic mul_start;
   logic [MulWidth-1:0] mul_mcand, mul_mplier;
   logic [2*MulWidth-1:0] mul_product;

   logic [1:0] state_ff, state_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [FrameWidth-1:0] frame_ff, frame_in;
   logic playing_ff, playing_in;
   logic wneg_ff, wneg_in;
   logic vneg_ff, vneg_in;
   logic [FadeWidth-1:0] fade_ff, fade_in;
   logic last_ff, last_in;
   logic [SampleWidth-1:0] res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SampleWidth-1:0] rsp_sample_ff, rsp_sample_in;
   logic rsp_last_ff, rsp_last_in;

   logic accept;
   logic [15:0] len;
   logic [PhaseWidth-1:0] phase_eff;
   logic [FrameWidth-1:0] frame_eff;
   logic [15:0] frame16;
   logic play_eff;
   logic produce;
   logic [FadeWidth-1:0] fade_val;
   logic last_val;
   logic [15:0] hval;
   logic hneg;
   logic [14:0] dmag;
   logic [15:0] abs_n;
   logic [15:0] wave_b;
   logic [14:0] vmag;
   logic [13:0] out_mag;
   logic out_load;

   dtgf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dtgf_sermul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .status  (mul_status),
      .product (mul_product)
   );

   assign req_stall = (state_ff != StIdle);
   assign accept = req_valid && !req_stall;

   // tick decode
   assign len = ({1'b0, cfg.tone_frames} > MaxLen) ? MaxLen : {1'b0, cfg.tone_frames};
   assign phase_eff = req_restart ? '0 : phase_ff;
   assign frame_eff = req_restart ? '0 : frame_ff;
   assign frame16 = {1'b0, frame_eff};
   assign play_eff = req_restart || playing_ff;
   assign produce = play_eff && (frame16 < len);
   assign last_val = (frame16 + 16'd1) >= len;

   always_comb begin
      if (frame16 < FadeLen) begin
         fade_val = {1'b0, frame_eff[8:0]};
      end else if ((len >= FadeLen) && (frame16 > (len - FadeLen))) begin
         fade_val = FadeWidth'(len - frame16);
      end else begin
         fade_val = FadeUnity;
      end
   end

   // parabola operands: |n| and 32768 - |n|, sign kept apart
   assign hval = phase_eff[15] ? 16'(FullWave - {1'b0, phase_eff}) : phase_eff;
   assign hneg = hval < QuarterWave;
   assign dmag = hneg ? 15'(QuarterWave - hval) : 15'(hval - QuarterWave);
   assign abs_n = {dmag, 1'b0};
   assign wave_b = 16'(HalfWave - {1'b0, abs_n});

   // floor of a negative product over 16384 rounds the magnitude up
   assign vmag = mul_product[28:14] + {14'b0, wneg_ff & (|mul_product[13:0])};
   // total scale of fade/512 then /2 is one truncation over 1024
   assign out_mag = mul_product[23:10];

   assign out_load = (state_ff == StOut) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      frame_in = frame_ff;
      playing_in = playing_ff;
      wneg_in = wneg_ff;
      vneg_in = vneg_ff;
      fade_in = fade_ff;
      last_in = last_ff;
      res_in = res_ff;
      mul_start = 1'b0;
      mul_mcand = abs_n;
      mul_mplier = wave_b;
      case (state_ff)
         StIdle: begin
            if (accept && play_eff) begin
               if (produce) begin
                  phase_in = phase_eff + cfg.phase_increment;
                  frame_in = frame_eff + 1'b1;
                  playing_in = !last_val;
                  wneg_in = hneg;
                  fade_in = fade_val;
                  last_in = last_val;
                  mul_start = 1'b1;
                  state_in = StWave;
               end else begin
                  phase_in = phase_eff;
                  frame_in = frame_eff;
                  playing_in = 1'b0;
               end
            end
         end
         StWave: begin
            mul_mcand = {1'b0, vmag};
            mul_mplier = {{(MulWidth-FadeWidth){1'b0}}, fade_ff};
            if (mul_status.done) begin
               vneg_in = wneg_ff && (vmag != '0);
               mul_start = 1'b1;
               state_in = StFade;
            end
         end
         StFade: begin
            if (mul_status.done) begin
               res_in = vneg_ff ? SampleWidth'(-{1'b0, out_mag}) : {1'b0, out_mag};
               state_in = StOut;
            end
         end
         StOut: begin
            if (out_load) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_sample_in = res_ff;
         rsp_last_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      wneg_ff <= wneg_in;
      vneg_ff <= vneg_in;
      fade_ff <= fade_in;
      last_ff <= last_in;
      res_ff <= res_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff <= StIdle;
         phase_ff <= '0;
         frame_ff <= '0;
         playing_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         frame_ff <= frame_in;
         playing_ff <= playing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last_frame = rsp_last_ff;

endmodule
